FILE: src/s256_pkg.sv
// s256_pkg: constants and round functions for the SHA-256 stream hasher.
// No dependencies.
`timescale 1ns / 1ps
package s256_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IvWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte   = 8'h80;
  localparam int unsigned LenStart = 56;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

FILE: src/s256_in_if.sv
// s256_in_if: input item channel (valid/ready).
// Depends on s256_pkg.
`timescale 1ns / 1ps
interface s256_in_if;
  import s256_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: src/s256_out_if.sv
// s256_out_if: result item channel (valid/ready).
// Depends on s256_pkg.
`timescale 1ns / 1ps
interface s256_out_if;
  import s256_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: src/sha256_stream_hasher.sv
// Streaming SHA-256 hasher. Absorb item: store the byte, plus a compression
// when the 64th byte of a block arrives (a load phase reading the block from a
// 64x8 synchronous memory, 64 rounds at one per cycle, then an add step).
// Finalize: one or two (plus one in double mode) compressed blocks,
// then eight result items. Reset clears all control state asynchronously.
// Depends on s256_pkg, s256_in_if, s256_out_if.
`timescale 1ns / 1ps
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  s256_in_if.sink     in_if,
  s256_out_if.source  out_if
);
  import s256_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StRnd  = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  localparam logic [1:0] SrcData = 2'd0;
  localparam logic [1:0] SrcPad  = 2'd1;
  localparam logic [1:0] SrcLen  = 2'd2;
  localparam logic [1:0] SrcDig  = 2'd3;

  logic [2:0]  st_q;
  logic        dbl_q;
  logic [60:0] cnt_q;
  logic [5:0]  fill_q;
  word_t       cv_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [6:0]  rc_q;
  logic [1:0]  bsrc_q;
  logic        fin_q;
  logic [2:0]  oi_q;

  logic [7:0]  mem [64];
  logic [7:0]  rd_q;
  logic [5:0]  rd_addr;

  // byte order: four bytes per schedule word, first byte most significant (load phase reads memory)
  logic [5:0]  lb;
  assign lb = rc_q[5:0];

  always_comb begin
    rd_addr = lb + 6'd1;
    if (st_q == StIdle) rd_addr = 6'd0;
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready && !in_if.payload.command) begin
      mem[fill_q] <= in_if.payload.data_byte;
    end
    rd_q <= mem[rd_addr];
  end

  // byte for position lb of current padded block (memory data is for lb)
  logic [7:0]  pb;
  logic [63:0] bits;
  logic [5:0]  lidx;
  logic [4:0]  didx;
  word_t       dw;
  assign bits = {cnt_q, 3'b000};
  assign lidx = lb - 6'(LenStart);
  assign didx = lb[4:0];
  assign dw   = cv_q[didx[4:2]];
  always_comb begin
    pb = 8'h00;
    case (bsrc_q)
      SrcData: begin
        if (!fin_q) pb = rd_q;
        else begin
          if (lb < fill_q) pb = rd_q;
          else if (lb == fill_q) pb = PadByte;
          if (fill_q < 6'(LenStart) && lb >= 6'(LenStart))
            pb = bits[8'(63 - 8 * lidx[2:0]) -: 8];
        end
      end
      SrcPad: begin
        if (lb == fill_q && !fin_q) pb = PadByte;
        if (lb >= 6'(LenStart)) pb = bits[8'(63 - 8 * lidx[2:0]) -: 8];
      end
      SrcLen: begin
        if (lb >= 6'(LenStart)) pb = bits[8'(63 - 8 * lidx[2:0]) -: 8];
      end
      SrcDig: begin
        if (lb < 6'd32) pb = dw[8'(31 - 8 * didx[1:0]) -: 8];
        else if (lb == 6'd32) pb = PadByte;
        else if (lb == 6'd62) pb = 8'h01;
      end
      default: pb = 8'h00;
    endcase
  end

  // round logic
  word_t wcur, wnew, t1, t2;
  logic  hasfull;
  assign wcur = w_q[0];
  assign wnew = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
              + RoundK[rc_q[5:0]] + wcur;
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign hasfull = 1'b0;

  logic acc;
  assign acc = in_if.valid && in_if.ready;
  assign in_if.ready = (st_q == StIdle);

  // control state machine and chaining value source for the next block start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      dbl_q  <= 1'b0;
      cnt_q  <= '0;
      fill_q <= '0;
      rc_q   <= '0;
      bsrc_q <= SrcData;
      fin_q  <= 1'b0;
      oi_q   <= '0;
      for (int i = 0; i < 8; i++) cv_q[i] <= IvWords[i];
    end else begin
      if (cfg_we_i) dbl_q <= cfg_wdata_i;
      case (st_q)
        StIdle: begin
          if (acc) begin
            rc_q <= '0;
            if (!in_if.payload.command) begin
              cnt_q  <= cnt_q + 61'd1;
              fill_q <= fill_q + 6'd1;
              if (fill_q == 6'd63) begin
                bsrc_q <= SrcData;
                fin_q  <= 1'b0;
                st_q   <= StLoad;
              end
            end else begin
              bsrc_q <= SrcData;
              fin_q  <= 1'b1;
              st_q   <= StLoad;
            end
          end
        end
        StLoad: begin
          rc_q <= rc_q + 7'd1;
          if (rc_q[5:0] == 6'd63) begin
            rc_q <= '0;
            st_q <= StRnd;
          end
        end
        StRnd: begin
          rc_q <= rc_q + 7'd1;
          if (rc_q[5:0] == 6'd63) st_q <= StAdd;
        end
        StAdd: begin
          rc_q <= '0;
          for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v_q[i];
          if (!fin_q) begin
            fill_q <= '0;
            st_q   <= StIdle;
          end else if (bsrc_q == SrcData && fill_q > 6'd55) begin
            bsrc_q <= SrcLen;
            st_q   <= StLoad;
          end else if (bsrc_q != SrcDig && dbl_q) begin
            bsrc_q <= SrcDig;
            st_q   <= StLoad;
          end else begin
            st_q <= StOut;
            oi_q <= '0;
          end
        end
        StOut: begin
          if (out_if.ready) begin
            oi_q <= oi_q + 3'd1;
            if (oi_q == 3'd7) begin
              st_q   <= StIdle;
              cnt_q  <= '0;
              fill_q <= '0;
              fin_q  <= 1'b0;
              for (int i = 0; i < 8; i++) cv_q[i] <= IvWords[i];
            end
          end
        end
        default: st_q <= StIdle;
      endcase
      // the digest block starts from the IV; capture digest into w path below
      if (st_q == StLoad && rc_q[5:0] == 6'd63 && bsrc_q == SrcDig) begin
        for (int i = 0; i < 8; i++) cv_q[i] <= IvWords[i];
      end
    end
  end

  // working variables and schedule window; load shifts the block in bytewise
  always_ff @(posedge clk_i) begin
    if (st_q == StLoad) begin
      for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
      w_q[15] <= {w_q[15][23:0], pb};
      if (rc_q[5:0] == 6'd63) begin
        for (int i = 0; i < 8; i++) v_q[i] <= (bsrc_q == SrcDig) ? IvWords[i] : cv_q[i];
      end
    end else if (st_q == StRnd) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2 + {31'd0, hasfull};
    end
  end

  assign out_if.valid = (st_q == StOut);
  assign out_if.payload.digest_word = cv_q[oi_q];
  assign out_if.payload.word_index  = oi_q;
  assign out_if.payload.last_word   = (oi_q == 3'd7);

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("output while accepting");
  a_fill_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && out_if.payload.last_word) |=> (fill_q == 6'd0))
    else $error("fill not cleared after digest");
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && !out_if.payload.last_word) |=> out_if.valid)
    else $error("digest words interrupted");
endmodule

FILE: test/tb_sha256_stream_hasher.sv
// tb_sha256_stream_hasher: self-checking bench for the streaming SHA-256 hasher.
// Predicts digests with its own SHA-256 model; depends on s256_pkg and the item interfaces.
`timescale 1ns / 1ps
module tb_sha256_stream_hasher;
  import s256_pkg::*;

  localparam logic CmdAbsorb   = 1'b0;
  localparam logic CmdFinalize = 1'b1;
  localparam int   LimitCycles = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  s256_in_if  in_ch ();
  s256_out_if out_ch ();

  sha256_stream_hasher uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  // predictor state
  word_t       chain_q [8];
  logic [60:0] msg_bytes;
  logic [7:0]  blk_buf [64];
  int          fill_cnt;
  logic        dbl_mode;

  out_item_t digest_q [$];
  int        mismatches = 0;
  int        words_seen = 0;
  int        items_sent = 0;
  int        cycle_cnt = 0;
  int        hold_off = 0;
  bit        burst_mode = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  function automatic word_t rr(word_t v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic sha_compress(inout word_t cv [8], input logic [7:0] b [64]);
    word_t w [64];
    word_t v [8];
    word_t t1, t2, e, a;
    for (int i = 0; i < 16; i++)
      w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
    v = cv;
    for (int i = 0; i < 64; i++) begin
      e = v[4];
      a = v[0];
      t1 = v[7] + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
         + RoundK[i] + w[i];
      t2 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) cv[i] = cv[i] + v[i];
  endtask

  task automatic put_len(inout logic [7:0] b [64], input logic [63:0] bits);
    for (int i = 0; i < 8; i++) b[56+i] = bits[63-8*i -: 8];
  endtask

  task automatic hasher_reset();
    chain_q = IvWords;
    msg_bytes = '0;
    fill_cnt = 0;
    dbl_mode = 1'b0;
    foreach (blk_buf[i]) blk_buf[i] = 8'h00;
  endtask

  task automatic predict_digest(input in_item_t it);
    logic [7:0] b [64];
    word_t res [8];
    out_item_t o;
    if (it.command == CmdAbsorb) begin
      blk_buf[fill_cnt] = it.data_byte;
      fill_cnt++;
      msg_bytes = msg_bytes + 61'd1;
      if (fill_cnt == 64) begin
        sha_compress(chain_q, blk_buf);
        fill_cnt = 0;
      end
      return;
    end
    foreach (b[i]) b[i] = (i < fill_cnt) ? blk_buf[i] : 8'h00;
    b[fill_cnt] = PadByte;
    if (fill_cnt + 1 > 56) begin
      sha_compress(chain_q, b);
      foreach (b[i]) b[i] = 8'h00;
    end
    put_len(b, {msg_bytes, 3'b000});
    sha_compress(chain_q, b);
    res = chain_q;
    if (dbl_mode) begin
      foreach (b[i]) b[i] = 8'h00;
      for (int i = 0; i < 8; i++)
        {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]} = res[i];
      b[32] = PadByte;
      put_len(b, 64'd256);
      res = IvWords;
      sha_compress(res, b);
    end
    for (int i = 0; i < 8; i++) begin
      o.digest_word = res[i];
      o.word_index = 3'(i);
      o.last_word = (i == 7);
      digest_q.push_back(o);
    end
    chain_q = IvWords;
    msg_bytes = '0;
    fill_cnt = 0;
  endtask

  // result checker and receiver stall pattern; values are taken just before the edge
  clocking mon_cb @(posedge clk_i);
    input o_valid   = out_ch.valid;
    input o_ready   = out_ch.ready;
    input o_payload = out_ch.payload;
  endclocking

  initial out_ch.ready = 1'b0;
  always @(mon_cb) begin
    out_item_t exp_w;
    out_item_t got_w;
    got_w = mon_cb.o_payload;
    if (mon_cb.o_valid && mon_cb.o_ready) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", got_w);
      end else begin
        exp_w = digest_q.pop_front();
        if (got_w !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp word %h idx %0d last %b, got %h idx %0d last %b",
                     exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                     got_w.digest_word, got_w.word_index, got_w.last_word);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (burst_mode) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0) || ((cycle_cnt % 64) < 16);
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
  end

  // Drives one item; valid stays high into the next call when no gap is drawn.
  task automatic send_item(input logic cmd, input logic [7:0] data, input bit gaps);
    in_item_t it;
    it.command = cmd;
    it.data_byte = data;
    @(negedge clk_i);
    if (gaps && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    predict_digest(it);
    items_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_double(input logic v);
    go_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    dbl_mode = v;
  endtask

  task automatic send_message(input int len, input bit gaps);
    for (int i = 0; i < len; i++) send_item(CmdAbsorb, 8'($urandom_range(0, 255)), gaps);
    send_item(CmdFinalize, 8'($urandom_range(0, 255)), gaps);
  endtask

  task automatic test_directed();
    send_item(CmdFinalize, 8'hff, 1'b0);          // empty message
    send_item(CmdAbsorb, 8'h00, 1'b0);
    send_item(CmdAbsorb, 8'hff, 1'b0);
    send_item(CmdAbsorb, 8'h5a, 1'b0);
    send_item(CmdFinalize, 8'h00, 1'b0);
    set_double(1'b1);
    send_item(CmdFinalize, 8'h00, 1'b0);          // double hash of empty
    send_item(CmdAbsorb, 8'ha5, 1'b0);
    send_item(CmdFinalize, 8'h00, 1'b0);
    set_double(1'b0);
  endtask

  task automatic test_pad_boundaries();
    int lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i], 1'b0);
  endtask

  task automatic test_backpressure();
    go_idle();
    hold_off = 2000;
    send_message(3, 1'b0);
    send_message(2, 1'b0);
    send_message(5, 1'b0);
    go_idle();
  endtask

  task automatic test_random(input int target);
    int start;
    start = items_sent;
    burst_mode = 1'b0;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 3) == 0) set_double(1'($urandom_range(0, 1)));
      send_message(($urandom_range(0, 4) == 0) ? $urandom_range(50, 70)
                                                : $urandom_range(0, 20), 1'b1);
    end
  endtask

  initial begin
    hasher_reset();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_pad_boundaries();
    test_backpressure();
    test_random(30);
    set_double(1'b1);
    send_message(10, 1'b1);
    set_double(1'b0);
    go_idle();
    $display("sent %0d items, checked %0d digest words incl. padding edges,", items_sent,
             words_seen);
    $display("single and double hashing, long output stall; %0d mismatches", mismatches);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
